FILE: design/lr3_pkg.sv
// ----------------------------------------------------------------------------
// lr3_pkg: shared types, constants and weight table functions
// Holds the controller states, register indexes and the elaboration-time
// builder of the normalized Q4.14 Lanczos-3 phase weights.
// ----------------------------------------------------------------------------
package lr3_pkg;

  localparam int RADIUS  = 3;
  localparam int TAPS    = 2 * RADIUS + 1;
  localparam int WW      = 18;              // weight width, signed Q4.14
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STEP_X        = 2'd2;
  localparam logic [1:0] REG_STEP_Y        = 2'd3;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOC1,
    ST_LOC2,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Shift-subtract quotient, used only while building constants.
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], a[k]};
      if (r >= b) begin
        r    = r - b;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint sin_pi_ratio(input logic [63:0] n_in, input logic [63:0] den);
    logic        neg;
    logic [63:0] n;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] dv;
    neg = 1'b0;
    n   = n_in - udiv(n_in, 2 * den) * (2 * den);
    if (n >= den) begin
      neg = 1'b1;
      n   = n - den;
    end
    if (2 * n > den) n = den - n;
    x  = udiv(PI_Q30 * n, den);
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int k = 0; k < 4; k++) begin
      case (k)
        0:       dv = 64'd72;
        1:       dv = 64'd42;
        2:       dv = 64'd20;
        default: dv = 64'd6;
      endcase
      t = ONE_Q30 - udiv((x2 * t) >> 30, dv);
    end
    x = (x * t) >> 30;
    return neg ? -longint'(x) : longint'(x);
  endfunction

  function automatic longint window_q30(input logic [63:0] a2, input int phases);
    logic [63:0] den;
    longint      s1;
    longint      s3;
    logic [63:0] m1;
    logic [63:0] m3;
    logic [63:0] x1;
    logic [63:0] x3;
    logic [63:0] c1;
    logic [63:0] c3;
    logic [63:0] prod;
    den = 64'(2 * RADIUS * phases);
    if (a2 == 0) return longint'(ONE_Q30);
    if (a2 >= den) return 0;
    s1 = sin_pi_ratio(a2 * RADIUS, den);
    s3 = sin_pi_ratio(a2, den);
    x1 = udiv(PI_Q30 * a2, 64'(2 * phases));
    x3 = udiv(PI_Q30 * a2, den);
    if (x1 == 0 || x3 == 0) return longint'(ONE_Q30);
    m1   = (s1 < 0) ? 64'(-s1) : 64'(s1);
    m3   = (s3 < 0) ? 64'(-s3) : 64'(s3);
    c1   = udiv(m1 << 30, x1);
    c3   = udiv(m3 << 30, x3);
    prod = (c1 * c3) >> 30;
    return ((s1 < 0) != (s3 < 0)) ? -longint'(prod) : longint'(prod);
  endfunction

  // Weight of tap k for phase p; the centre tap absorbs the rounding remainder.
  function automatic logic signed [WW-1:0] lanczos_weight(input int phases, input int p,
                                                           input int k);
    longint      raw [TAPS];
    longint      sum;
    longint      wsum;
    longint      u2;
    longint      w;
    longint      res;
    logic [63:0] m;
    logic [63:0] q;
    sum  = 0;
    wsum = 0;
    res  = 0;
    for (int kk = 0; kk < TAPS; kk++) begin
      u2      = 2 * longint'(kk - RADIUS) * phases + phases - 2 * p;
      raw[kk] = window_q30(64'((u2 < 0) ? -u2 : u2), phases);
      sum     = sum + raw[kk];
    end
    if (sum <= 0) sum = longint'(ONE_Q30);
    for (int kk = 0; kk < TAPS; kk++) begin
      m    = (raw[kk] < 0) ? 64'(-raw[kk]) : 64'(raw[kk]);
      q    = udiv(m * 64'd32768 + 64'(sum), 64'(2 * sum));
      w    = (raw[kk] < 0) ? -longint'(q) : longint'(q);
      wsum = wsum + w;
      if (kk == k) res = w;
    end
    if (k == RADIUS) res = res + 16384 - wsum;
    return WW'(res);
  endfunction

endpackage

FILE: design/lanczos3_image_resampler_unit.sv
// ----------------------------------------------------------------------------
// lanczos3_image_resampler_unit: Lanczos-3 resampler over a frame memory
// Flow: a compute beat passes the locate states LOC1 and LOC2, 49 tap reads from the
//   single frame memory port (one source sample per cycle), the MAC pipeline and the
//   drain and done states; in_ready stays low until its result is loaded, so only
//   one compute is in flight. Writes go at one per cycle while the block is idle.
// Reset: rst clears the controller, the pipeline valids and the output valid, and
//   loads the register defaults; the frame memory keeps its contents.
// ----------------------------------------------------------------------------
module lanczos3_image_resampler_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PHASES     = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [15:0] sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pixel,
  output logic        clipped
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int LWX   = $clog2(MAX_WIDTH + 1);
  localparam int LWY   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(PHASES);
  localparam int PRW   = 16 + $clog2(PHASES + 1);
  localparam int WW    = lr3_pkg::WW;
  localparam int TAPS  = lr3_pkg::TAPS;
  localparam int HW    = WW + 17;          // horizontal product
  localparam int ACCW  = HW + 3;           // row sum of seven products
  localparam int TOTW  = WW + ACCW + 4;    // vertical sum
  localparam logic [2:0] TAP_LAST = 3'(TAPS - 1);
  localparam logic [2:0] TAP_RAD  = 3'(lr3_pkg::RADIUS);

  // Phase weight table, built at elaboration.
  logic signed [WW-1:0] wtab [PHASES][TAPS];
  for (genvar gp = 0; gp < PHASES; gp++) begin : g_phase
    for (genvar gk = 0; gk < TAPS; gk++) begin : g_tap
      localparam logic signed [WW-1:0] WVAL = lr3_pkg::lanczos_weight(PHASES, gp, gk);
      assign wtab[gp][gk] = WVAL;
    end
  end

  // Configuration registers.
  logic [8:0]  source_width, source_height;
  logic [20:0] step_x, step_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 9'd256;
      source_height <= 9'd256;
      step_x        <= 21'd65536;
      step_y        <= 21'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        lr3_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[8:0];
        lr3_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data[8:0];
        lr3_pkg::REG_STEP_X:        step_x        <= cfg_data;
        lr3_pkg::REG_STEP_Y:        step_y        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective plane size: zero acts as one, oversize clamps to the store.
  logic [LWX-1:0] lim_w;
  logic [LWY-1:0] lim_h;
  always_comb begin
    if (source_width == 9'd0) lim_w = LWX'(1);
    else if (13'(source_width) > 13'(MAX_WIDTH)) lim_w = LWX'(MAX_WIDTH);
    else lim_w = LWX'(source_width);
    if (source_height == 9'd0) lim_h = LWY'(1);
    else if (13'(source_height) > 13'(MAX_HEIGHT)) lim_h = LWY'(MAX_HEIGHT);
    else lim_h = LWY'(source_height);
  end

  // Controller.
  lr3_pkg::state_t state, state_next;
  logic [2:0] tap_i, tap_i_next, tap_j, tap_j_next;
  logic       tot_v;
  logic       load_out;
  logic       issue;

  logic in_fire;
  assign in_ready = (state == lr3_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lr3_pkg::ST_IDLE;
      tap_i <= '0;
      tap_j <= '0;
    end else begin
      state <= state_next;
      tap_i <= tap_i_next;
      tap_j <= tap_j_next;
    end
  end

  always_comb begin
    state_next = state;
    tap_i_next = tap_i;
    tap_j_next = tap_j;
    load_out   = 1'b0;
    issue      = 1'b0;
    case (state)
      lr3_pkg::ST_IDLE: begin
        if (in_fire && action == lr3_pkg::ACT_COMPUTE) state_next = lr3_pkg::ST_LOC1;
      end
      lr3_pkg::ST_LOC1: state_next = lr3_pkg::ST_LOC2;
      lr3_pkg::ST_LOC2: begin
        state_next = lr3_pkg::ST_RUN;
        tap_i_next = '0;
        tap_j_next = '0;
      end
      lr3_pkg::ST_RUN: begin
        issue = 1'b1;
        if (tap_i == TAP_LAST) begin
          tap_i_next = '0;
          tap_j_next = tap_j + 3'd1;
          if (tap_j == TAP_LAST) state_next = lr3_pkg::ST_DRAIN;
        end else begin
          tap_i_next = tap_i + 3'd1;
        end
      end
      lr3_pkg::ST_DRAIN: begin
        if (tot_v) state_next = lr3_pkg::ST_DONE;
      end
      lr3_pkg::ST_DONE: begin
        // Hold the finished sum until the output register is free.
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = lr3_pkg::ST_IDLE;
        end
      end
      default: state_next = lr3_pkg::ST_IDLE;
    endcase
  end

  // Locate: source position t = o * step + 1/2, then centre and phase.
  logic [11:0] req_x, req_y;
  logic [33:0] t_x, t_y;
  logic [CW-1:0] cx;
  logic [RW-1:0] cy;
  logic [PW-1:0] phx, phy;
  logic [PRW-1:0] ph_px, ph_py;

  assign ph_px = PRW'(t_x[15:0]) * PRW'(PHASES);
  assign ph_py = PRW'(t_y[15:0]) * PRW'(PHASES);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_x <= pos_x;
      req_y <= pos_y;
    end
    if (state == lr3_pkg::ST_LOC1) begin
      t_x <= 34'(req_x) * 34'(step_x) + 34'h8000;
      t_y <= 34'(req_y) * 34'(step_y) + 34'h8000;
    end
    if (state == lr3_pkg::ST_LOC2) begin
      cx  <= (t_x[33:16] > 18'(lim_w - LWX'(1))) ? CW'(lim_w - LWX'(1)) : CW'(t_x[33:16]);
      cy  <= (t_y[33:16] > 18'(lim_h - LWY'(1))) ? RW'(lim_h - LWY'(1)) : RW'(t_y[33:16]);
      phx <= PW'(ph_px >> 16);
      phy <= PW'(ph_py >> 16);
    end
  end

  // Tap address with edge clamping.
  logic signed [CW+2:0] col_s;
  logic signed [RW+2:0] row_s;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  always_comb begin
    col_s = $signed({3'b000, cx}) + $signed({{CW{1'b0}}, tap_i}) - $signed({{CW{1'b0}}, TAP_RAD});
    row_s = $signed({3'b000, cy}) + $signed({{RW{1'b0}}, tap_j}) - $signed({{RW{1'b0}}, TAP_RAD});
    if (col_s < 0) col = '0;
    else if (col_s > $signed((CW+3)'(lim_w) - (CW+3)'(1))) col = CW'(lim_w - LWX'(1));
    else col = CW'(col_s);
    if (row_s < 0) row = '0;
    else if (row_s > $signed((RW+3)'(lim_h) - (RW+3)'(1))) row = RW'(lim_h - LWY'(1));
    else row = RW'(row_s);
  end

  // Frame memory: single port, writes in idle, reads while running.
  logic [15:0] frame_store [DEPTH];
  logic [15:0] mem_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;

  assign rd_addr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
  assign wr_addr = AW'(pos_y) * AW'(MAX_WIDTH) + AW'(pos_x);
  assign wr_en   = in_fire && action == lr3_pkg::ACT_WRITE &&
                   13'(pos_x) < 13'(MAX_WIDTH) && 13'(pos_y) < 13'(MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (wr_en) frame_store[wr_addr] <= sample;
    else if (issue) mem_q <= frame_store[rd_addr];
  end

  // MAC pipeline: sample, horizontal product, row sum, vertical product, total.
  logic       s1_v, s2_v, s3_v, s4_v;
  logic [2:0] s1_i, s1_j, s2_i, s2_j, s3_j, s4_j;
  logic signed [HW-1:0]   prod_h;
  logic signed [ACCW-1:0] acc_h, row_sum;
  logic signed [TOTW-1:0] prod_v, total;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      tot_v <= 1'b0;
    end else begin
      s1_v  <= issue;
      s2_v  <= s1_v;
      s3_v  <= s2_v && s2_i == TAP_LAST;
      s4_v  <= s3_v;
      tot_v <= s4_v && s4_j == TAP_LAST;
    end
  end

  always_ff @(posedge clk) begin
    s1_i <= tap_i;
    s1_j <= tap_j;
    s2_i <= s1_i;
    s2_j <= s1_j;
    if (s1_v) prod_h <= HW'(wtab[phx][s1_i] * $signed({1'b0, mem_q}));
    if (s2_v) begin
      // Restart the row sum on its first tap; publish it on the last.
      acc_h <= (s2_i == 3'd0) ? ACCW'(prod_h) : acc_h + ACCW'(prod_h);
      if (s2_i == TAP_LAST) begin
        row_sum <= acc_h + ACCW'(prod_h);
        s3_j    <= s2_j;
      end
    end
    if (s3_v) begin
      prod_v <= TOTW'(wtab[phy][s3_j] * row_sum);
      s4_j   <= s3_j;
    end
    if (s4_v) total <= (s4_j == 3'd0) ? prod_v : total + prod_v;
  end

  // Round half up from Q28 and saturate.
  logic signed [TOTW-1:0] rounded;
  logic [15:0] pix_next;
  logic        clip_next;
  always_comb begin
    rounded = total + (TOTW'(1) <<< 27);
    if (rounded < 0) begin
      pix_next  = 16'd0;
      clip_next = 1'b1;
    end else if (rounded[TOTW-1:44] != '0) begin
      pix_next  = 16'hFFFF;
      clip_next = 1'b1;
    end else begin
      pix_next  = rounded[43:28];
      clip_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      pixel   <= pix_next;
      clipped <= clip_next;
    end
  end

  // Checks.
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(s1_v || s2_v || s3_v || s4_v || tot_v))
    else $error("input taken while taps still in flight");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == lr3_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_total_in_drain: assert property (@(posedge clk) disable iff (rst)
    tot_v |-> state == lr3_pkg::ST_DRAIN)
    else $error("final sum arrived outside drain");

endmodule

FILE: sim/lr3_resample_checker.sv
// ----------------------------------------------------------------------------
// lr3_resample_checker: shadow predictor and scoreboard for the resampler
// Mirrors the register file and the frame memory from the observed beats,
// predicts each output pixel with its own Lanczos-3 weight table and
// compares every result beat against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module lr3_resample_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        action,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [15:0] sample,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] pixel,
  input  logic        clipped,
  output int          errors,
  output int          pending
);

  localparam int NPH  = 64;
  localparam int SIDE = 256;
  localparam logic [63:0] Q30  = 64'd1 << 30;
  localparam logic [63:0] PIQ  = 64'd3373259426;

  typedef struct packed {
    logic [15:0] pixel;
    logic        clipped;
  } pix_t;

  pix_t        pixel_queue[$];
  int          weight_lut [NPH][lr3_pkg::TAPS];
  logic [15:0] frame_copy [SIDE*SIDE];
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [20:0] stepx_reg;
  logic [20:0] stepy_reg;
  int          fail_count;

  assign errors  = fail_count;
  assign pending = pixel_queue.size();

  // sin(pi * n / den) in signed Q30 by a folded Taylor series
  function automatic longint sine_q30(input logic [63:0] n_in, input logic [63:0] den);
    logic        neg;
    logic [63:0] n;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] dv;
    neg = 1'b0;
    n   = n_in % (2 * den);
    if (n >= den) begin
      neg = 1'b1;
      n   = n - den;
    end
    if (2 * n > den) n = den - n;
    x  = PIQ * n / den;
    x2 = (x * x) >> 30;
    t  = Q30;
    for (int k = 0; k < 4; k++) begin
      dv = (k == 0) ? 64'd72 : (k == 1) ? 64'd42 : (k == 2) ? 64'd20 : 64'd6;
      t  = Q30 - ((x2 * t) >> 30) / dv;
    end
    x = (x * t) >> 30;
    return neg ? -longint'(x) : longint'(x);
  endfunction

  // windowed sinc at |u| = a2 / (2*NPH), Q30
  function automatic longint lobe_q30(input logic [63:0] a2);
    logic [63:0] den;
    longint      s1;
    longint      s3;
    logic [63:0] m1;
    logic [63:0] m3;
    logic [63:0] x1;
    logic [63:0] x3;
    logic [63:0] prod;
    den = 64'(2 * lr3_pkg::RADIUS * NPH);
    if (a2 == 0) return longint'(Q30);
    if (a2 >= den) return 0;
    s1 = sine_q30(a2 * lr3_pkg::RADIUS, den);
    s3 = sine_q30(a2, den);
    x1 = PIQ * a2 / 64'(2 * NPH);
    x3 = PIQ * a2 / den;
    if (x1 == 0 || x3 == 0) return longint'(Q30);
    m1   = (s1 < 0) ? 64'(-s1) : 64'(s1);
    m3   = (s3 < 0) ? 64'(-s3) : 64'(s3);
    prod = (((m1 << 30) / x1) * ((m3 << 30) / x3)) >> 30;
    return ((s1 < 0) != (s3 < 0)) ? -longint'(prod) : longint'(prod);
  endfunction

  initial begin
    longint      raw [lr3_pkg::TAPS];
    longint      total;
    longint      wsum;
    longint      u2;
    logic [63:0] m;
    logic [63:0] q;
    fail_count = 0;
    for (int p = 0; p < NPH; p++) begin
      total = 0;
      wsum  = 0;
      for (int k = 0; k < lr3_pkg::TAPS; k++) begin
        u2     = 2 * longint'(k - lr3_pkg::RADIUS) * NPH + NPH - 2 * p;
        raw[k] = lobe_q30(64'((u2 < 0) ? -u2 : u2));
        total  = total + raw[k];
      end
      if (total <= 0) total = longint'(Q30);
      for (int k = 0; k < lr3_pkg::TAPS; k++) begin
        m = (raw[k] < 0) ? 64'(-raw[k]) : 64'(raw[k]);
        q = (m * 64'd32768 + 64'(total)) / 64'(2 * total);
        weight_lut[p][k] = (raw[k] < 0) ? -int'(q) : int'(q);
        wsum = wsum + weight_lut[p][k];
      end
      weight_lut[p][lr3_pkg::RADIUS] += int'(16384 - wsum);
    end
  end

  function automatic int plane_span(input logic [8:0] v);
    if (v == 0) return 1;
    return (v > SIDE) ? SIDE : int'(v);
  endfunction

  function automatic int edge_clamp(input int v, input int lim);
    if (v < 0) return 0;
    if (v > lim - 1) return lim - 1;
    return v;
  endfunction

  function automatic pix_t resample_at(input logic [11:0] ox, input logic [11:0] oy);
    int          w;
    int          h;
    logic [63:0] tx;
    logic [63:0] ty;
    int          cx;
    int          cy;
    int          phx;
    int          phy;
    int          row;
    longint      acc;
    longint      sum;
    pix_t        r;
    w   = plane_span(width_reg);
    h   = plane_span(height_reg);
    tx  = 64'(ox) * 64'(stepx_reg) + 64'h8000;
    ty  = 64'(oy) * 64'(stepy_reg) + 64'h8000;
    cx  = ((tx >> 16) > 64'(w - 1)) ? w - 1 : int'(tx >> 16);
    cy  = ((ty >> 16) > 64'(h - 1)) ? h - 1 : int'(ty >> 16);
    phx = int'(((tx & 64'hFFFF) * NPH) >> 16);
    phy = int'(((ty & 64'hFFFF) * NPH) >> 16);
    sum = 0;
    for (int j = 0; j < lr3_pkg::TAPS; j++) begin
      row = edge_clamp(cy + j - lr3_pkg::RADIUS, h);
      acc = 0;
      for (int i = 0; i < lr3_pkg::TAPS; i++)
        acc += longint'(weight_lut[phx][i]) *
               longint'(frame_copy[row * SIDE + edge_clamp(cx + i - lr3_pkg::RADIUS, w)]);
      sum += longint'(weight_lut[phy][j]) * acc;
    end
    sum += longint'(1) << 27;
    r.clipped = 1'b0;
    if (sum < 0) begin
      r.pixel   = '0;
      r.clipped = 1'b1;
    end else if ((sum >>> 28) > 65535) begin
      r.pixel   = 16'hFFFF;
      r.clipped = 1'b1;
    end else begin
      r.pixel = 16'(sum >>> 28);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pix_t got;
    pix_t want;
    if (rst) begin
      width_reg  <= 9'd256;
      height_reg <= 9'd256;
      stepx_reg  <= 21'd65536;
      stepy_reg  <= 21'd65536;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lr3_pkg::REG_SOURCE_WIDTH:  width_reg  <= cfg_data[8:0];
          lr3_pkg::REG_SOURCE_HEIGHT: height_reg <= cfg_data[8:0];
          lr3_pkg::REG_STEP_X:        stepx_reg  <= cfg_data;
          lr3_pkg::REG_STEP_Y:        stepy_reg  <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (action == lr3_pkg::ACT_WRITE) begin
          if (pos_x < SIDE && pos_y < SIDE) frame_copy[pos_y * SIDE + pos_x] = sample;
        end else begin
          pixel_queue.push_back(resample_at(pos_x, pos_y));
        end
      end
      if (out_valid && out_ready) begin
        got.pixel   = pixel;
        got.clipped = clipped;
        if (pixel_queue.size() == 0) begin
          $error("result beat with no pixel pending: pixel %0d clipped %0d", pixel, clipped);
          fail_count++;
        end else begin
          want = pixel_queue.pop_front();
          if (got.pixel !== want.pixel) begin
            $error("pixel mismatch: expected %0d, got %0d", want.pixel, got.pixel);
            fail_count++;
          end
          if (got.clipped !== want.clipped) begin
            $error("clipped mismatch: expected %0d, got %0d", want.clipped, got.clipped);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

FILE: sim/lanczos3_image_resampler_unit_tb.sv
// ----------------------------------------------------------------------------
// lanczos3_image_resampler_unit_tb: stimulus and verdict for the resampler
// Paints the source plane on demand so that every tap a compute beat reads
// has been written, sweeps several register settings including the extremes
// and out-of-range sizes and steps, and stalls both channels at random.
// ----------------------------------------------------------------------------
module lanczos3_image_resampler_unit_tb;

  localparam int SIDE        = 256;
  localparam int STALL_MAX   = 13;
  localparam int QUIET_LIMIT = 3000;  // cycles with no beat on either channel
  localparam int SETTLE      = 80;    // extra wait after the last pending pixel is taken
  localparam int PHASE_BEATS = 160;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [20:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [15:0] sample;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] pixel;
  logic        clipped;
  int          errors;
  int          pending;

  // Mirror of what the block holds, used to paint missing taps.
  bit          painted [SIDE*SIDE];
  logic [8:0]  width_now;
  logic [8:0]  height_now;
  logic [20:0] stepx_now;
  logic [20:0] stepy_now;

  bit calm;         // no idling on either side while set
  int beats_sent;
  int n_writes;
  int n_offstore;
  int n_computes;
  int n_settings;
  int quiet;

  lanczos3_image_resampler_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .pos_x(pos_x),
    .pos_y(pos_y), .sample(sample), .out_valid(out_valid), .out_ready(out_ready),
    .pixel(pixel), .clipped(clipped)
  );

  lr3_resample_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .pos_x(pos_x),
    .pos_y(pos_y), .sample(sample), .out_valid(out_valid), .out_ready(out_ready),
    .pixel(pixel), .clipped(clipped), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int stall_draw();
    return calm ? 0 : int'($urandom_range(0, STALL_MAX));
  endfunction

  // Result side: hold ready low for a drawn number of cycles before each beat.
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = stall_draw();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic int plane_span(input logic [8:0] v);
    if (v == 0) return 1;
    return (v > SIDE) ? SIDE : int'(v);
  endfunction

  function automatic int clamp_to(input int v, input int lim);
    if (v < 0) return 0;
    return (v > lim - 1) ? lim - 1 : v;
  endfunction

  function automatic int centre_of(input logic [11:0] pos, input logic [20:0] step,
                                   input int lim);
    logic [63:0] t;
    t = 64'(pos) * 64'(step) + 64'h8000;
    return ((t >> 16) > 64'(lim - 1)) ? lim - 1 : int'(t >> 16);
  endfunction

  // Favor full-scale and black samples so alternating pixels drive the
  // negative lobes into saturation.
  function automatic logic [15:0] sample_draw();
    case ($urandom_range(0, 3))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] coord_draw();
    return ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 4095))
                                       : 12'($urandom_range(0, 300));
  endfunction

  // Present one beat after a drawn gap; hold valid and payload until accepted.
  task automatic send_beat(input logic act, input logic [11:0] x, input logic [11:0] y,
                           input logic [15:0] s);
    int n;
    n = stall_draw();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    pos_x    <= x;
    pos_y    <= y;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic store_sample(input logic [11:0] x, input logic [11:0] y,
                              input logic [15:0] s);
    send_beat(lr3_pkg::ACT_WRITE, x, y, s);
    n_writes++;
    if (x < SIDE && y < SIDE) painted[y * SIDE + x] = 1'b1;
    else n_offstore++;
  endtask

  // Paint every tap of the 7x7 footprint that was never written, then compute.
  task automatic compute_pixel(input logic [11:0] x, input logic [11:0] y);
    int w;
    int h;
    int cx;
    int cy;
    int r;
    int c;
    w  = plane_span(width_now);
    h  = plane_span(height_now);
    cx = centre_of(x, stepx_now, w);
    cy = centre_of(y, stepy_now, h);
    for (int j = -lr3_pkg::RADIUS; j <= lr3_pkg::RADIUS; j++) begin
      for (int i = -lr3_pkg::RADIUS; i <= lr3_pkg::RADIUS; i++) begin
        r = clamp_to(cy + j, h);
        c = clamp_to(cx + i, w);
        if (!painted[r * SIDE + c]) store_sample(12'(c), 12'(r), sample_draw());
      end
    end
    send_beat(lr3_pkg::ACT_COMPUTE, x, y, 16'($urandom));
    n_computes++;
  endtask

  // Drop valid, wait out every pending pixel, then let the block go idle.
  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all four registers back to back with the enable held high.
  task automatic load_regs(input logic [8:0] w, input logic [8:0] h,
                           input logic [20:0] sx, input logic [20:0] sy);
    cfg_we    <= 1'b1;
    cfg_index <= lr3_pkg::REG_SOURCE_WIDTH;
    cfg_data  <= 21'(w);
    @(posedge clk);
    cfg_index <= lr3_pkg::REG_SOURCE_HEIGHT;
    cfg_data  <= 21'(h);
    @(posedge clk);
    cfg_index <= lr3_pkg::REG_STEP_X;
    cfg_data  <= sx;
    @(posedge clk);
    cfg_index <= lr3_pkg::REG_STEP_Y;
    cfg_data  <= sy;
    @(posedge clk);
    cfg_we     <= 1'b0;
    width_now  = w;
    height_now = h;
    stepx_now  = sx;
    stepy_now  = sy;
    n_settings++;
  endtask

  task automatic random_phase();
    int stop_at;
    stop_at = beats_sent + PHASE_BEATS;
    while (beats_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: compute_pixel(coord_draw(), coord_draw());
        5, 6, 7: store_sample(12'($urandom_range(0, plane_span(width_now) - 1)),
                              12'($urandom_range(0, plane_span(height_now) - 1)),
                              sample_draw());
        8: store_sample(12'($urandom), 12'($urandom), 16'($urandom));
        default: store_sample(12'($urandom_range(0, SIDE - 1)),
                              12'($urandom_range(0, SIDE - 1)), sample_draw());
      endcase
    end
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= lr3_pkg::REG_SOURCE_WIDTH;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    action     <= lr3_pkg::ACT_WRITE;
    pos_x      <= '0;
    pos_y      <= '0;
    sample     <= '0;
    width_now  = 9'd256;
    height_now = 9'd256;
    stepx_now  = 21'd65536;
    stepy_now  = 21'd65536;
    calm       = 1'b0;
    beats_sent = 0;
    n_writes   = 0;
    n_offstore = 0;
    n_computes = 0;
    n_settings = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corner samples, writes outside the store, corner and far
    // coordinates under the reset settings.
    store_sample(12'd0, 12'd0, 16'hFFFF);
    store_sample(12'd255, 12'd255, 16'h0000);
    store_sample(12'd4095, 12'd4095, 16'hFFFF);
    store_sample(12'd256, 12'd0, 16'h5A5A);
    store_sample(12'd0, 12'd256, 16'hA5A5);
    compute_pixel(12'd0, 12'd0);
    compute_pixel(12'd4095, 12'd4095);
    compute_pixel(12'd255, 12'd0);
    compute_pixel(12'd0, 12'd255);
    compute_pixel(12'd128, 12'd128);
    drain_all();

    // Settings: 1x1 plane at step 1/16, full plane at step 16, zero and oversized sizes
    // with zero and all-ones steps, small random ones, 300x64, and the defaults.
    for (int ph = 0; ph < 6; ph++) begin
      drain_all();
      case (ph)
        0: load_regs(9'd1, 9'd1, 21'd4096, 21'd4096);
        1: load_regs(9'd256, 9'd256, 21'd1048576, 21'd1048576);
        2: load_regs(9'd0, 9'd511, 21'd0, 21'h1FFFFF);
        3: load_regs(9'($urandom_range(2, 40)), 9'($urandom_range(2, 40)),
                     21'($urandom_range(4096, 1048576)), 21'($urandom_range(4096, 1048576)));
        4: load_regs(9'd300, 9'd64, 21'd32768, 21'd98304);
        default: load_regs(9'd256, 9'd256, 21'd65536, 21'd65536);
      endcase
      calm = (ph == 3);
      random_phase();
    end
    calm = 1'b0;

    drain_all();
    $display("Covered %0d sample writes (%0d outside the store) and %0d output pixels",
             n_writes, n_offstore, n_computes);
    $display("over %0d register settings with random stalls on both channels", n_settings);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
